[sv/cmdtok_pkg.sv]
package cmdtok_pkg;

  // Classified character, as handed from the front end to the back end.
  typedef struct packed {
    logic       line_start;
    logic       is_cap_o;
    logic       is_space;
    logic       is_term;
    logic       is_minus;
    logic       is_digit;
    logic       is_bin_digit;
    logic       is_b;
    logic       is_h;
    logic       is_hex_letter;
    logic       is_word;
    logic       is_stray;
    logic [3:0] nibble;
    logic [7:0] upper;
  } tok_t;

  // Results one character may leave behind; later ones overwrite the last slot.
  localparam int unsigned ResultCap  = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChUpO     = 8'h4F;
  localparam logic [7:0] ChUpZ     = 8'h5A;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowB    = 8'h62;
  localparam logic [7:0] ChLowH    = 8'h68;
  localparam logic [7:0] ChLowZ    = 8'h7A;
  localparam logic [7:0] ChCaseOfs = 8'h20;

endpackage

[sv/cmdtok_char_if.sv]
interface cmdtok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_start;

  modport source (output valid, ch, line_start, input ready);
  modport sink (input valid, ch, line_start, output ready);
endinterface

[sv/cmdtok_param_if.sv]
interface cmdtok_param_if;
  logic               valid;
  logic               ready;
  logic               param_valid;
  logic signed [15:0] param_value;
  logic [2:0]         param_index;
  logic               line_done;
  logic [2:0]         param_count;
  logic               last_of_run;

  modport source (output valid, param_valid, param_value, param_index, line_done,
                  param_count, last_of_run, input ready);
  modport sink (input valid, param_valid, param_value, param_index, line_done,
                param_count, last_of_run, output ready);
endinterface

[sv/cmdtok_front.sv]
module cmdtok_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmdtok_char_if.sink        char_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output cmdtok_pkg::tok_t   push_data_o
);
  import cmdtok_pkg::*;

  function automatic tok_t classify(logic [7:0] c, logic ls);
    tok_t       t;
    logic [7:0] u;
    u               = (c >= ChLowA && c <= ChLowZ) ? (c - ChCaseOfs) : c;
    t.line_start    = ls;
    t.is_cap_o      = (c == ChUpO);
    t.is_space      = (c == ChSpace);
    t.is_term       = (c == ChNul) || (c == ChGt);
    t.is_minus      = (c == ChMinus);
    t.is_digit      = (c >= ChZero) && (c <= ChNine);
    t.is_bin_digit  = (c == ChZero) || (c == ChOne);
    t.is_b          = (c == ChLowB);
    t.is_h          = (c == ChLowH);
    t.is_hex_letter = (u >= ChUpA) && (u <= ChUpF);
    t.is_word       = ((u >= ChUpA) && (u <= ChUpZ)) || (u == ChUnder);
    t.is_stray      = !(t.is_space || t.is_term || t.is_minus || t.is_digit || t.is_word);
    t.nibble        = t.is_digit ? c[3:0] : (u[3:0] + 4'd9);
    t.upper         = u;
    return t;
  endfunction

  logic valid_q;
  tok_t tok_q;

  assign char_i.ready = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_data_o  = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (char_i.ready) begin
      valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      tok_q <= classify(char_i.ch, char_i.line_start);
    end
  end

endmodule

[sv/cmdtok_queue.sv]
module cmdtok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  cmdtok_pkg::tok_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output cmdtok_pkg::tok_t pop_data_o
);
  import cmdtok_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tok_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    rd_d  = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_d;
      if (pop) rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[sv/cmdtok_back.sv]
module cmdtok_back #(
  parameter int unsigned MAX_PARAMS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  input  cmdtok_pkg::tok_t head_i,
  cmdtok_param_if.source   param_o
);
  import cmdtok_pkg::*;

  localparam int unsigned FoundW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned RunW   = $clog2(ResultCap);

  typedef enum logic [2:0] {
    PhIdle    = 3'b001,
    PhBetween = 3'b010,
    PhBuild   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ModeDec = 2'd0,
    ModeHex = 2'd1,
    ModeBin = 2'd2
  } mode_e;

  typedef struct packed {
    logic        consume;
    logic [15:0] acc;
    mode_e       mode;
  } build_t;

  // One character folded into a parameter under construction.
  function automatic build_t build_fn(logic [15:0] acc, mode_e mode, tok_t t);
    build_t r;
    r.consume = 1'b1;
    r.acc     = acc;
    r.mode    = mode;
    if (t.is_b) begin
      r.mode = ModeBin;
    end else if (t.is_h) begin
      r.mode = ModeHex;
    end else if (mode == ModeBin) begin
      if (t.is_bin_digit) r.acc = {acc[14:0], t.nibble[0]};
      else r.consume = 1'b0;
    end else if (t.is_digit) begin
      r.acc = (mode == ModeHex) ? {acc[11:0], t.nibble}
                                : {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {12'h000, t.nibble};
    end else if (mode == ModeHex && t.is_hex_letter) begin
      r.acc = {acc[11:0], t.nibble};
    end else if (t.is_word) begin
      r.acc = ({acc[10:0], 5'b00000} + acc) ^ {8'h00, t.upper};
    end else begin
      r.consume = 1'b0;
    end
    return r;
  endfunction

  phase_e            phase_q, phase_d;
  logic [15:0]       acc_q, acc_d;
  logic              neg_q, neg_d;
  mode_e             mode_q, mode_d;
  logic              hexdef_q, hexdef_d;
  logic [FoundW-1:0] found_q, found_d;
  logic [RunW-1:0]   run_q, run_d;

  logic              out_valid_q;
  logic              out_pvalid_q, out_done_q, out_last_q;
  logic [15:0]       out_value_q;
  logic [2:0]        out_index_q, out_count_q;

  build_t            bstep, fstep;
  mode_e             dflt_mode;
  logic              between, pop, full_next;
  logic              has_res, res_valid, res_done;
  logic [15:0]       res_value;
  logic [FoundW-1:0] res_index;
  logic              want_emit, out_free, fire;

  assign dflt_mode = hexdef_q ? ModeHex : ModeDec;
  assign full_next = (found_q == FoundW'(MAX_PARAMS - 1));
  assign bstep     = build_fn(acc_q, mode_q, head_i);
  assign fstep     = build_fn(16'h0000, dflt_mode, head_i);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    mode_d    = mode_q;
    hexdef_d  = hexdef_q;
    found_d   = found_q;
    between   = 1'b0;
    pop       = 1'b0;
    has_res   = 1'b0;
    res_valid = 1'b0;
    res_done  = 1'b0;
    res_value = 16'h0000;
    res_index = found_q;
    if (head_i.line_start) begin
      // Opcode: open a fresh line, abandon whatever was in progress.
      hexdef_d = head_i.is_cap_o;
      found_d  = '0;
      acc_d    = 16'h0000;
      neg_d    = 1'b0;
      mode_d   = ModeDec;
      phase_d  = PhBetween;
      pop      = 1'b1;
    end else begin
      unique case (phase_q)
        PhIdle: pop = 1'b1;
        PhBetween: between = 1'b1;
        PhBuild: begin
          if (bstep.consume) begin
            acc_d  = bstep.acc;
            mode_d = bstep.mode;
            pop    = 1'b1;
          end else begin
            has_res   = 1'b1;
            res_valid = 1'b1;
            res_value = neg_q ? (~acc_q + 16'h0001) : acc_q;
            found_d   = found_q + 1'b1;
            if (full_next) begin
              res_done = 1'b1;
              phase_d  = PhIdle;
              pop      = 1'b1;
            end else begin
              phase_d = PhBetween;
              between = 1'b1;
            end
          end
        end
        default: pop = 1'b1;
      endcase
      if (between) begin
        mode_d = dflt_mode;
        if (head_i.is_space) begin
          pop = 1'b1;
        end else if (head_i.is_term) begin
          phase_d  = PhIdle;
          pop      = 1'b1;
          res_done = 1'b1;
          if (!has_res) begin
            has_res   = 1'b1;
            res_index = '0;
          end
        end else if (head_i.is_minus) begin
          phase_d = PhBuild;
          acc_d   = 16'h0000;
          neg_d   = 1'b1;
          pop     = 1'b1;
        end else if (!head_i.is_stray) begin
          phase_d = PhBuild;
          acc_d   = fstep.acc;
          mode_d  = fstep.mode;
          neg_d   = 1'b0;
          pop     = 1'b1;
        end else if (!has_res) begin
          // Stray delimiter: one zero parameter per cycle while the output is free, until the table is full.
          has_res   = 1'b1;
          res_valid = 1'b1;
          found_d   = found_q + 1'b1;
          acc_d     = 16'h0000;
          neg_d     = 1'b0;
          if (full_next) begin
            res_done = 1'b1;
            phase_d  = PhIdle;
            pop      = 1'b1;
          end
        end
        // Stray right after a finished parameter: hold the head; the fill follows once the state has advanced.
      end
    end
  end

  // Past the result cap only the final result of a character is delivered.
  assign want_emit  = has_res && ((run_q < RunW'(ResultCap - 1)) || pop);
  assign out_free   = !out_valid_q || param_o.ready;
  assign fire       = head_valid_i && (!want_emit || out_free);
  assign head_pop_o = fire && pop;

  always_comb begin
    run_d = run_q;
    if (pop) begin
      run_d = '0;
    end else if (has_res && run_q != RunW'(ResultCap - 1)) begin
      run_d = run_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      acc_q    <= 16'h0000;
      neg_q    <= 1'b0;
      mode_q   <= ModeDec;
      hexdef_q <= 1'b0;
      found_q  <= '0;
      run_q    <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      mode_q   <= mode_d;
      hexdef_q <= hexdef_d;
      found_q  <= found_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && want_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && want_emit) begin
      out_pvalid_q <= res_valid;
      out_value_q  <= res_value;
      out_index_q  <= 3'(res_index);
      out_done_q   <= res_done;
      out_count_q  <= 3'(found_d);
      out_last_q   <= pop;
    end
  end

  assign param_o.valid       = out_valid_q;
  assign param_o.param_valid = out_pvalid_q;
  assign param_o.param_value = out_value_q;
  assign param_o.param_index = out_index_q;
  assign param_o.line_done   = out_done_q;
  assign param_o.param_count = out_count_q;
  assign param_o.last_of_run = out_last_q;

endmodule

[sv/command_line_number_tokenizer.sv]
// Streaming tokenizer for ASCII command lines. Feed one character per beat on
// char_i, with line_start set on the opcode character; parameters come out on
// param_o as they complete, each tagged with its index, the running count,
// line_done on the last beat of a line and last_of_run on the last beat a
// character causes. Numbers are decimal, or hex when the opcode is 'O'; 'b'
// and 'h' switch a parameter to binary or hex, a leading '-' negates it, and
// words fold into a shift-xor hash; all arithmetic wraps at 16 bits. A
// character is classified in a front register, waits in a two-entry queue and
// is executed by the back end, which owns all parsing state and the output
// register. The back end retires one character per cycle, unless the receiver
// holds the output register, when it completes at most one parameter; a
// character that completes several parameters (a stray delimiter filling
// zeros to MAX_PARAMS) holds it until the last, one result per cycle into the
// single output register while the receiver keeps up. Past five results of
// one character only its final result is delivered as a beat, but every
// result is still produced in turn. There is no clearing pass after reset.
module command_line_number_tokenizer #(
  parameter int unsigned MAX_PARAMS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cmdtok_char_if.sink    char_i,
  cmdtok_param_if.source param_o
);
  import cmdtok_pkg::*;

  // Front register to queue.
  logic fq_valid, fq_ready;
  tok_t fq_data;

  // Queue head to back end.
  logic qb_valid, qb_pop;
  tok_t qb_data;

  // Classify each accepted character and hold it for the queue.
  cmdtok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_i),
    .push_valid_o (fq_valid),
    .push_ready_i (fq_ready),
    .push_data_o  (fq_data)
  );

  // Decouple classification from execution so a multi-beat fill does not
  // stall the input side right away.
  cmdtok_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_pop),
    .pop_data_o   (qb_data)
  );

  // Advance the parser; drop a character from the queue on its last beat.
  cmdtok_back #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (qb_valid),
    .head_pop_o   (qb_pop),
    .head_i       (qb_data),
    .param_o      (param_o)
  );

`ifndef NO_ASSERTIONS
  // A line always closes on the last beat of its character.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    param_o.valid && param_o.line_done |-> param_o.last_of_run)
    else $error("line_done without last_of_run");

  // An empty beat only ever reports a line end.
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    param_o.valid && !param_o.param_valid |->
      param_o.line_done && param_o.param_value == 16'sd0 && param_o.param_index == 3'd0)
    else $error("empty beat that is not a bare line end");

  // The count on a parameter beat includes that parameter.
  a_count_tracks_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    param_o.valid && param_o.param_valid |->
      param_o.param_count == 3'(param_o.param_index + 3'd1))
    else $error("param_count out of step with param_index");

  // The back end only retires a character that is in the queue.
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_pop |-> qb_valid)
    else $error("queue popped while empty");
`endif

endmodule

[test/tb_command_line_number_tokenizer.sv]
`timescale 1ns / 100ps

module tb_command_line_number_tokenizer;
  import cmdtok_pkg::*;

  localparam int unsigned MaxParams  = 6;
  localparam int unsigned LiveTarget = 400;     // parsed characters after which random lines stop
  localparam int unsigned LongHold   = 300;     // receiver hold-off, in cycles
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 12;      // margin to catch any extra beat

  // Parser state as the tokenizer sees it between characters.
  typedef enum logic [1:0] {SCAN_IDLE, SCAN_GAP, SCAN_NUMBER} scan_e;
  typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_BIN} radix_e;

  // One output beat, field for field.
  typedef struct packed {
    logic               pvalid;
    logic signed [15:0] value;
    logic [2:0]         index;
    logic               done;
    logic [2:0]         count;
    logic               last;
  } param_beat_t;

  // Tracks the line being parsed and keeps the parameter beats still owed.
  class param_tracker;
    scan_e        scan;
    radix_e       radix;
    logic [15:0]  acc;
    bit           neg;
    bit           hex_default;
    int unsigned  found;
    param_beat_t  pending[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  live_chars;
    int unsigned  lines;

    function new();
      scan        = SCAN_IDLE;
      radix       = RADIX_DEC;
      acc         = '0;
      neg         = 1'b0;
      hex_default = 1'b0;
      found       = 0;
      errors      = 0;
      checked     = 0;
      live_chars  = 0;
      lines       = 0;
    endfunction

    function void take_char(logic [7:0] c, logic ls);
      int unsigned first;
      bit          consumed;
      bit          done;
      bit          emitted;
      bit          finish;
      logic [7:0]  u;
      param_beat_t beat;
      first    = pending.size();
      consumed = 1'b0;
      done     = 1'b0;
      emitted  = 1'b0;
      if (ls) begin
        hex_default = (c == ChUpO);
        found       = 0;
        acc         = '0;
        neg         = 1'b0;
        radix       = RADIX_DEC;
        scan        = SCAN_GAP;
        lines++;
        live_chars++;
        return;
      end
      if (scan != SCAN_IDLE) live_chars++;
      while (!consumed) begin
        case (scan)
          SCAN_IDLE: begin
            consumed = 1'b1;
          end
          SCAN_GAP: begin
            radix = hex_default ? RADIX_HEX : RADIX_DEC;
            if (c == ChSpace) begin
              consumed = 1'b1;
            end else if (c == ChNul || c == ChGt) begin
              done     = 1'b1;
              scan     = SCAN_IDLE;
              consumed = 1'b1;
            end else begin
              acc  = '0;
              neg  = 1'b0;
              scan = SCAN_NUMBER;
              if (c == ChMinus) begin
                neg      = 1'b1;
                consumed = 1'b1;
              end
            end
          end
          default: begin
            finish = 1'b0;
            u      = c;
            if (c == ChLowB) begin
              radix    = RADIX_BIN;
              consumed = 1'b1;
            end else if (c == ChLowH) begin
              radix    = RADIX_HEX;
              consumed = 1'b1;
            end else if (radix == RADIX_BIN) begin
              if (c == ChZero || c == ChOne) begin
                acc      = {acc[14:0], c[0]};
                consumed = 1'b1;
              end else begin
                finish = 1'b1;
              end
            end else if (c >= ChZero && c <= ChNine) begin
              if (radix == RADIX_HEX) acc = (acc << 4) + 16'(c - ChZero);
              else acc = acc * 16'd10 + 16'(c - ChZero);
              consumed = 1'b1;
            end else begin
              if (u >= ChLowA && u <= ChLowZ) u = u - ChCaseOfs;
              if (radix == RADIX_HEX && u >= ChUpA && u <= ChUpF) begin
                acc      = (acc << 4) + 16'(u - ChUpA) + 16'd10;
                consumed = 1'b1;
              end else if (u == ChUnder || (u >= ChUpA && u <= ChUpZ)) begin
                acc      = (acc * 16'd33) ^ {8'h00, u};
                consumed = 1'b1;
              end else begin
                finish = 1'b1;
              end
            end
            if (finish) begin
              beat.pvalid = 1'b1;
              beat.value  = neg ? 16'(-acc) : acc;
              beat.index  = found[2:0];
              found++;
              beat.count  = found[2:0];
              beat.done   = 1'b0;
              beat.last   = 1'b0;
              pending.push_back(beat);
              emitted = 1'b1;
              scan    = SCAN_GAP;
              if (found >= MaxParams) begin
                done     = 1'b1;
                scan     = SCAN_IDLE;
                consumed = 1'b1;
              end
            end
          end
        endcase
      end
      if (done) begin
        if (emitted) begin
          pending[pending.size() - 1].done = 1'b1;
        end else begin
          beat.pvalid = 1'b0;
          beat.value  = '0;
          beat.index  = '0;
          beat.done   = 1'b1;
          beat.count  = found[2:0];
          beat.last   = 1'b0;
          pending.push_back(beat);
        end
      end
      if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_param(param_beat_t got);
      param_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display({"%0t: beat with nothing expected: valid %0b value %0d index %0d",
                    " done %0b count %0d last %0b"},
                   $time, got.pvalid, got.value, got.index, got.done, got.count, got.last);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pvalid !== want.pvalid || got.value !== want.value ||
          got.index !== want.index || got.done !== want.done ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        if (errors <= 30)
          $display({"%0t: mismatch expected v%0b %0d i%0d d%0b c%0d l%0b",
                    " actual v%0b %0d i%0d d%0b c%0d l%0b"},
                   $time, want.pvalid, want.value, want.index, want.done, want.count,
                   want.last, got.pvalid, got.value, got.index, got.done, got.count,
                   got.last);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  int unsigned  cycle_count;
  bit           hold_request;   // ask the receiver for one long hold-off
  bit           quiet_tail;     // no idling on either side from here on
  bit           sender_calm;    // this line goes out back to back
  param_tracker tracker;

  cmdtok_char_if  char_bus ();
  cmdtok_param_if param_bus ();

  command_line_number_tokenizer #(
    .MAX_PARAMS (MaxParams)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .char_i  (char_bus),
    .param_o (param_bus)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: end the run as a failure once the cycle limit is reached.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sample both channels at the edge, before any driver update lands.
  // Note the input beat first so that its expectations exist before any
  // output beat of the same edge is checked.
  always @(posedge clk) begin
    param_beat_t got;
    if (rst_n && tracker != null) begin
      if (char_bus.valid === 1'b1 && char_bus.ready === 1'b1)
        tracker.take_char(char_bus.ch, char_bus.line_start);
      if (param_bus.valid === 1'b1 && param_bus.ready === 1'b1) begin
        got.pvalid = param_bus.param_valid;
        got.value  = param_bus.param_value;
        got.index  = param_bus.param_index;
        got.done   = param_bus.line_done;
        got.count  = param_bus.param_count;
        got.last   = param_bus.last_of_run;
        tracker.check_param(got);
      end
    end
  end

  // Receiver: alternate stretches of no back pressure with stretches of short
  // random stalls, and honor one long hold-off while the sender keeps going.
  initial begin
    int stretch_left;
    int stall_pct;
    stretch_left = 0;
    stall_pct    = 0;
    param_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    param_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      stretch_left--;
      if (hold_request) begin
        // Hold ready low long enough for the internal queue to fill and the
        // input side to stall.
        hold_request = 1'b0;
        param_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        param_bus.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        param_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        param_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one character and hold it until the block takes the beat; then
  // maybe drop valid for a short burst.
  task automatic send_char(logic [7:0] c, logic ls);
    char_bus.valid      <= 1'b1;
    char_bus.ch         <= c;
    char_bus.line_start <= ls;
    do @(posedge clk); while (char_bus.ready !== 1'b1);
    if (!quiet_tail && !sender_calm && $urandom_range(0, 4) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // One random line. Most lines are well formed with random content; a few
  // are raw byte noise with the occasional stray line start.
  task automatic send_random_line();
    string      dec_set;
    string      hex_set;
    string      word_set;
    string      mix_set;
    string      stray_set;
    int         nparams;
    int         len;
    logic [7:0] op;
    dec_set   = "0123456789";
    hex_set   = "0123456789abcdefABCDEF";
    word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    mix_set   = "0123456789abcdefhxyzABXZ_-";
    stray_set = "!,;:.=+*/#()";
    sender_calm = ($urandom_range(0, 2) == 0);
    op = ($urandom_range(0, 3) == 0) ? ChUpO : 8'($urandom_range(33, 126));
    send_char(op, 1'b1);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(3, 12))
        send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      return;
    end
    nparams = $urandom_range(0, 8);
    for (int p = 0; p < nparams; p++) begin
      repeat ($urandom_range(0, 2)) send_char(ChSpace, 1'b0);
      if ($urandom_range(0, 3) == 0) send_char(ChMinus, 1'b0);
      case ($urandom_range(0, 4))
        0: begin
          len = $urandom_range(1, 6);
          repeat (len) send_char(dec_set[$urandom_range(0, 9)], 1'b0);
        end
        1: begin
          send_char(ChLowH, 1'b0);
          len = $urandom_range(1, 5);
          repeat (len) send_char(hex_set[$urandom_range(0, hex_set.len() - 1)], 1'b0);
        end
        2: begin
          send_char(ChLowB, 1'b0);
          len = $urandom_range(1, 18);
          repeat (len) send_char($urandom_range(0, 1) ? ChOne : ChZero, 1'b0);
        end
        3: begin
          len = $urandom_range(1, 6);
          repeat (len) send_char(word_set[$urandom_range(0, word_set.len() - 1)], 1'b0);
        end
        default: begin
          len = $urandom_range(1, 6);
          repeat (len) send_char(mix_set[$urandom_range(0, mix_set.len() - 1)], 1'b0);
        end
      endcase
      send_char(ChSpace, 1'b0);
    end
    // Close the line: NUL, '>', a stray delimiter, or leave it for the next
    // line start to abandon.
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_char(ChNul, 1'b0);
      5, 6, 7:       send_char(ChGt, 1'b0);
      8: begin
        if ($urandom_range(0, 1)) send_char(8'hFF, 1'b0);
        else send_char(stray_set[$urandom_range(0, stray_set.len() - 1)], 1'b0);
      end
      default: ;
    endcase
  endtask

  // Main stimulus.
  initial begin
    bit held;
    bit paused;
    held         = 1'b0;
    paused       = 1'b0;
    hold_request = 1'b0;
    quiet_tail   = 1'b0;
    sender_calm  = 1'b0;
    tracker      = new();
    rst_n               <= 1'b0;
    char_bus.valid      <= 1'b0;
    char_bus.ch         <= '0;
    char_bus.line_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines.
    // A top-code byte while idle: drop it, no beat.
    send_char(8'hFF, 1'b0);
    // Hex opcode; a top-code stray byte ends the first parameter and then
    // fills zeros until the table is full.
    send_char(ChUpO, 1'b1);
    send_text("f");
    send_char(8'hFF, 1'b0);
    // Decimal line: negated hex switch, binary switch, word hash with a
    // trailing digit, and '>' ending the line right after a parameter.
    send_char("D", 1'b1);
    send_text("-h7FFF b10 _z9 -5>");
    // A line abandoned by a new line start, then NUL with nothing pending.
    send_char("Q", 1'b1);
    send_text("1");
    send_char("R", 1'b1);
    send_char(ChNul, 1'b0);

    // Random lines, with one long receiver hold-off, one full drain and a
    // quiet tail with no idling at all.
    while (tracker.live_chars < LiveTarget) begin
      send_random_line();
      if (!held && tracker.live_chars >= 150) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      if (!paused && tracker.live_chars >= 300) begin
        paused = 1'b1;
        char_bus.valid <= 1'b0;
        // Let the sampler note the last accepted character first.
        @(posedge clk);
        while (tracker.pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (tracker.live_chars >= LiveTarget - 60) quiet_tail = 1'b1;
    end
    char_bus.valid <= 1'b0;

    // Drain: wait for every owed beat, then for a margin to catch
    // anything extra.
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("run covered %0d lines and %0d parsed characters; %0d parameter beats checked",
             tracker.lines, tracker.live_chars, tracker.checked);
    $display("mismatching beats: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
